@@ src/twm_pkg.sv @@
// Shared types, widths and codes for the trapezoid weight mapper.
// No dependencies.
`timescale 1ns / 1ps
package twm_pkg;

	localparam int W      = 24;         // weight width, Q8.16
	localparam int F      = 16;         // fraction bits
	localparam int DW     = W + 1;      // width of a breakpoint difference
	localparam int PW     = 2 * DW;     // width of the exact product
	localparam int QB     = W + 2;      // quotient bits kept by the divider
	localparam int NDIV   = (QB + 1) / 2; // divider stages, two bits each
	localparam int RW     = W + 3;      // width of the unsaturated result

	localparam logic signed [W-1:0] ONE_Q = W'(1) << F;

	localparam logic [2:0] SEG_BELOW   = 3'd0;
	localparam logic [2:0] SEG_RISE    = 3'd1;
	localparam logic [2:0] SEG_PLATEAU = 3'd2;
	localparam logic [2:0] SEG_FALL    = 3'd3;
	localparam logic [2:0] SEG_ABOVE   = 3'd4;

	localparam logic [2:0] REG_DRIVER_LOW  = 3'd0;
	localparam logic [2:0] REG_DRIVER_HIGH = 3'd1;
	localparam logic [2:0] REG_RISE_START  = 3'd2;
	localparam logic [2:0] REG_RISE_END    = 3'd3;
	localparam logic [2:0] REG_FALL_START  = 3'd4;
	localparam logic [2:0] REG_FALL_END    = 3'd5;
	localparam logic [2:0] REG_DRIVEN_LOW  = 3'd6;
	localparam logic [2:0] REG_DRIVEN_HIGH = 3'd7;

	typedef struct packed {
		logic signed [W-1:0] weight;
		logic                animating;
		logic                driven_animates;
	} in_t;

	typedef struct packed {
		logic signed [W-1:0] mapped_weight;
		logic signed [W-1:0] applied_weight;
		logic [2:0]          segment;
		logic                saturated;
	} out_t;

	typedef struct packed {
		logic signed [W-1:0] driver_low;
		logic signed [W-1:0] driver_high;
		logic signed [W-1:0] rise_start;
		logic signed [W-1:0] rise_end;
		logic signed [W-1:0] fall_start;
		logic signed [W-1:0] fall_end;
		logic signed [W-1:0] driven_low;
		logic signed [W-1:0] driven_high;
	} cfg_t;

	// Sideband that rides along with an item through the divider.
	typedef struct packed {
		logic signed [W-1:0] applied;
		logic [2:0]          seg;
		logic signed [W-1:0] base;
		logic                interp;
		logic                neg;
	} meta_t;

endpackage

@@ src/twm_front.sv @@
// Front end: clamp, segment decode and slope operand select (two stages).
// Depends on twm_pkg.
`timescale 1ns / 1ps
module twm_front import twm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  in_t             in_item,
	input  cfg_t            cfg,
	output logic            v_s2,
	output meta_t           meta_s2,
	output logic [DW-1:0]   mag1_s2,
	output logic [DW-1:0]   mag2_s2,
	output logic [DW-1:0]   den_s2
);

	logic                v_s1;
	logic                anim_s1;
	logic signed [W-1:0] cur_s1;
	logic signed [W-1:0] cur;

	always_comb begin
		cur = in_item.weight;
		if (!in_item.animating) begin
			if (cur < cfg.driver_low) cur = cfg.driver_low;
			if (cur > cfg.driver_high) cur = cfg.driver_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			// drop animating items whose driven side does not animate
			v_s1 <= in_valid && !(in_item.animating && !in_item.driven_animates);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s1  <= cur;
			anim_s1 <= in_item.animating;
		end
	end

	// Segment decode and choice of slope endpoints
	logic signed [W-1:0]  a, b, from_v, to_v;
	meta_t                meta;
	logic signed [DW-1:0] n1, n2, den;

	always_comb begin
		meta.applied = cur_s1;
		meta.seg     = SEG_BELOW;
		meta.base    = cfg.driven_low;
		meta.interp  = 1'b0;
		a      = cfg.rise_start;
		b      = cfg.rise_end;
		from_v = cfg.driven_low;
		to_v   = cfg.driven_high;
		if (anim_s1 && cur_s1 < cfg.rise_start) begin
			meta.seg = SEG_BELOW;
			if (cfg.rise_start != cfg.driver_low) meta.base = cfg.driven_low;
			else if (cfg.rise_start == cfg.rise_end) meta.base = cfg.driven_high;
			else meta.interp = 1'b1;
		end else if (anim_s1 && cur_s1 > cfg.fall_end) begin
			meta.seg = SEG_ABOVE;
			a      = cfg.fall_start;
			b      = cfg.fall_end;
			from_v = cfg.driven_high;
			to_v   = cfg.driven_low;
			if (cfg.fall_end != cfg.driver_high) meta.base = cfg.driven_low;
			else if (cfg.fall_end == cfg.fall_start) meta.base = cfg.driven_high;
			else meta.interp = 1'b1;
		end else if (cur_s1 <= cfg.rise_start) begin
			meta.seg  = SEG_BELOW;
			meta.base = (cfg.rise_start == cfg.rise_end && cfg.rise_start <= cfg.driver_low)
				? cfg.driven_high : cfg.driven_low;
		end else if (cur_s1 <= cfg.rise_end) begin
			meta.seg    = SEG_RISE;
			meta.interp = 1'b1;
		end else if (cur_s1 <= cfg.fall_start) begin
			meta.seg  = SEG_PLATEAU;
			meta.base = cfg.driven_high;
		end else if (cur_s1 <= cfg.fall_end) begin
			meta.seg    = SEG_FALL;
			meta.interp = 1'b1;
			a      = cfg.fall_start;
			b      = cfg.fall_end;
			from_v = cfg.driven_high;
			to_v   = cfg.driven_low;
		end else begin
			meta.seg  = SEG_ABOVE;
			meta.base = (cfg.fall_start >= cfg.driver_high) ? cfg.driven_high : cfg.driven_low;
		end
		if (meta.interp) meta.base = from_v;
		n1  = DW'(cur_s1) - DW'(a);
		n2  = DW'(to_v) - DW'(from_v);
		den = DW'(b) - DW'(a);
		meta.neg = n1[DW-1] ^ n2[DW-1] ^ den[DW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta;
			mag1_s2 <= n1[DW-1] ? DW'(-n1) : DW'(n1);
			mag2_s2 <= n2[DW-1] ? DW'(-n2) : DW'(n2);
			den_s2  <= den[DW-1] ? DW'(-den) : DW'(den);
		end
	end

endmodule

@@ src/twm_divider.sv @@
// Multiply and restoring divide pipeline: |n1|*|n2| / |den|, two quotient
// bits per stage, with overflow detection. Depends on twm_pkg.
`timescale 1ns / 1ps
module twm_divider import twm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  meta_t           meta_in,
	input  logic [DW-1:0]   mag1,
	input  logic [DW-1:0]   mag2,
	input  logic [DW-1:0]   den,
	output logic            v_out,
	output meta_t           meta_out,
	output logic [QB-1:0]   quo,
	output logic            ovf
);

	// product stage
	logic            v_m;
	meta_t           meta_m;
	logic [PW-1:0]   prod_m;
	logic [DW-1:0]   den_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else if (en) v_m <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_m <= meta_in;
			prod_m <= PW'(mag1) * PW'(mag2);
			den_m  <= den;
		end
	end

	// stage arrays: index 0 is the overflow check, then NDIV divide stages
	logic            v_d    [NDIV+1];
	meta_t           meta_d [NDIV+1];
	logic [DW-1:0]   rem_d  [NDIV+1];
	logic [QB-1:0]   low_d  [NDIV+1];
	logic [QB-1:0]   quo_d  [NDIV+1];
	logic [DW-1:0]   den_d  [NDIV+1];
	logic            ovf_d  [NDIV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d[0] <= 1'b0;
		else if (en) v_d[0] <= v_m;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_d[0] <= meta_m;
			// quotient would need more than QB bits
			ovf_d[0]  <= DW'(prod_m[PW-1:QB]) >= den_m;
			rem_d[0]  <= DW'(prod_m[PW-1:QB]);
			low_d[0]  <= prod_m[QB-1:0];
			quo_d[0]  <= '0;
			den_d[0]  <= den_m;
		end
	end

	for (genvar s = 0; s < NDIV; s++) begin : g_div
		logic [DW-1:0] rem_n;
		logic [QB-1:0] low_n;
		logic [QB-1:0] quo_n;
		logic [DW:0]   t0, t1;

		always_comb begin
			rem_n = rem_d[s];
			low_n = low_d[s];
			quo_n = quo_d[s];
			t0 = {rem_n, low_n[QB-1]};
			if (t0 >= {1'b0, den_d[s]}) begin
				rem_n = DW'(t0 - {1'b0, den_d[s]});
				quo_n = {quo_n[QB-2:0], 1'b1};
			end else begin
				rem_n = t0[DW-1:0];
				quo_n = {quo_n[QB-2:0], 1'b0};
			end
			low_n = {low_n[QB-2:0], 1'b0};
			t1 = {rem_n, low_n[QB-1]};
			if (2 * s + 1 < QB) begin
				if (t1 >= {1'b0, den_d[s]}) begin
					rem_n = DW'(t1 - {1'b0, den_d[s]});
					quo_n = {quo_n[QB-2:0], 1'b1};
				end else begin
					rem_n = t1[DW-1:0];
					quo_n = {quo_n[QB-2:0], 1'b0};
				end
				low_n = {low_n[QB-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[s+1] <= 1'b0;
			else if (en) v_d[s+1] <= v_d[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_d[s+1] <= meta_d[s];
				rem_d[s+1]  <= rem_n;
				low_d[s+1]  <= low_n;
				quo_d[s+1]  <= quo_n;
				den_d[s+1]  <= den_d[s];
				ovf_d[s+1]  <= ovf_d[s];
			end
		end
	end

	assign v_out    = v_d[NDIV];
	assign meta_out = meta_d[NDIV];
	assign quo      = quo_d[NDIV];
	assign ovf      = ovf_d[NDIV];

endmodule

@@ src/trapezoid_weight_mapper_core.sv @@
// Top level of the trapezoid weight mapper: configuration registers, front end,
// divider pipeline and result register. Depends on twm_pkg, twm_front, twm_divider.
`timescale 1ns / 1ps
// Maps a Q8.16 driver weight to a driven weight through a trapezoid set by
// eight configuration registers (written on wr_en, index wr_index; write only
// while no item is in flight). The block is a single stalling pipeline: one
// item enters per cycle unless the pipeline is held; its result goes through
// the front end, the product stage, the overflow check and the restoring
// divider, two quotient bits per stage. A result waiting in the output
// register with result_ready low holds the whole pipeline; item_ready is high
// whenever the output register is empty or being drained. Animating items
// whose driven side does not animate enter as bubbles and give no result.
// Slope values saturate to the signed range and raise saturated.
module trapezoid_weight_mapper_core import twm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  in_t           item,
	output logic          result_valid,
	input  logic          result_ready,
	output out_t          result,
	input  logic          wr_en,
	input  logic [2:0]    wr_index,
	input  logic [W-1:0]  wr_data
);

	cfg_t cfg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.driver_low  <= '0;
			cfg_q.driver_high <= ONE_Q;
			cfg_q.rise_start  <= '0;
			cfg_q.rise_end    <= ONE_Q;
			cfg_q.fall_start  <= ONE_Q;
			cfg_q.fall_end    <= ONE_Q;
			cfg_q.driven_low  <= '0;
			cfg_q.driven_high <= ONE_Q;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DRIVER_LOW:  cfg_q.driver_low  <= wr_data;
				REG_DRIVER_HIGH: cfg_q.driver_high <= wr_data;
				REG_RISE_START:  cfg_q.rise_start  <= wr_data;
				REG_RISE_END:    cfg_q.rise_end    <= wr_data;
				REG_FALL_START:  cfg_q.fall_start  <= wr_data;
				REG_FALL_END:    cfg_q.fall_end    <= wr_data;
				REG_DRIVEN_LOW:  cfg_q.driven_low  <= wr_data;
				REG_DRIVEN_HIGH: cfg_q.driven_high <= wr_data;
				default: ;
			endcase
		end
	end

	// Advance every stage unless a result is stuck in the output register
	logic en;
	assign en         = !result_valid || result_ready;
	assign item_ready = en;

	logic          v_s2;
	meta_t         meta_s2;
	logic [DW-1:0] mag1_s2, mag2_s2, den_s2;

	twm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (item_valid),
		.in_item  (item),
		.cfg      (cfg_q),
		.v_s2     (v_s2),
		.meta_s2  (meta_s2),
		.mag1_s2  (mag1_s2),
		.mag2_s2  (mag2_s2),
		.den_s2   (den_s2)
	);

	logic          v_dv;
	meta_t         meta_dv;
	logic [QB-1:0] quo_dv;
	logic          ovf_dv;

	twm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s2),
		.meta_in  (meta_s2),
		.mag1     (mag1_s2),
		.mag2     (mag2_s2),
		.den      (den_s2),
		.v_out    (v_dv),
		.meta_out (meta_dv),
		.quo      (quo_dv),
		.ovf      (ovf_dv)
	);

	// Cap the quotient, apply the sign, add the base and saturate
	localparam logic [QB-1:0]        QCAP  = QB'(1) << (W + 1);
	localparam logic signed [RW-1:0] R_MAX = RW'((64'sd1 <<< (W - 1)) - 1);
	localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);

	logic [QB-1:0]        q;
	logic signed [RW-1:0] r;
	out_t                 res;

	always_comb begin
		q = (ovf_dv || quo_dv > QCAP) ? QCAP : quo_dv;
		r = meta_dv.neg ? RW'(meta_dv.base) - RW'(signed'({1'b0, q}))
			: RW'(meta_dv.base) + RW'(signed'({1'b0, q}));
		res.applied_weight = meta_dv.applied;
		res.segment        = meta_dv.seg;
		res.saturated      = 1'b0;
		res.mapped_weight  = meta_dv.base;
		if (meta_dv.interp) begin
			if (r > R_MAX) begin
				res.mapped_weight = R_MAX[W-1:0];
				res.saturated     = 1'b1;
			end else if (r < R_MIN) begin
				res.mapped_weight = R_MIN[W-1:0];
				res.saturated     = 1'b1;
			end else begin
				res.mapped_weight = r[W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else if (en) result_valid <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (en) result <= res;
	end

	// Checks
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.segment <= SEG_ABOVE)
		else $error("segment code out of range");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
			result.mapped_weight == R_MAX[W-1:0] || result.mapped_weight == R_MIN[W-1:0])
		else $error("saturated result not at a rail");

	a_plateau: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.segment == SEG_PLATEAU |->
			result.mapped_weight == cfg_q.driven_high && !result.saturated)
		else $error("plateau result differs from driven_high");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for trapezoid_weight_mapper_core: directed table, then random phases.
// Depends on twm_pkg and the core; carries its own predictor of the trapezoid mapping.
`timescale 1ns / 1ps
module tb_top;
	import twm_pkg::*;

	localparam int  LIMIT      = 600000;
	localparam int  DRAIN      = 40;   // well past the NDIV+5 pipeline depth
	localparam int  N_PHASES   = 30;
	localparam int  PHASE_ITEMS = 45;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_t  item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_t result;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = REG_DRIVER_LOW;
	logic [W-1:0] wr_data = '0;

	trapezoid_weight_mapper_core DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cfg_t cur_cfg;
	out_t pending_results[$];
	int   mismatches = 0;
	int   cycles = 0;
	bit   hold_go = 1'b0;

	typedef struct {
		in_t  x;
		bit   typed;
		out_t want;
	} dir_row_t;

	// Clip to the signed weight range and flag it.
	function automatic longint clip_w(longint v, ref bit flag);
		longint mx, mn;
		mx = (longint'(1) << (W - 1)) - 1;
		mn = -mx - 1;
		if (v > mx) begin
			flag = 1'b1;
			return mx;
		end
		if (v < mn) begin
			flag = 1'b1;
			return mn;
		end
		return v;
	endfunction

	// from + trunc((x - a) * (to - from) / (b - a)), exact product, capped quotient.
	function automatic longint slope_value(longint x, longint a, longint b,
			longint from, longint to, ref bit flag);
		longint n1, n2, den;
		longint unsigned m1, m2, md, q, cap;
		bit neg;
		n1 = x - a;
		n2 = to - from;
		den = b - a;
		if (den == 0) return clip_w(from, flag);
		neg = ((n1 < 0) != (n2 < 0)) != (den < 0);
		m1 = n1 < 0 ? -n1 : n1;
		m2 = n2 < 0 ? -n2 : n2;
		md = den < 0 ? -den : den;
		cap = longint'(1) << (W + 1);
		q = (m1 * m2) / md;
		if (q > cap) q = cap;
		if (n1 == 0 || n2 == 0) q = 0;
		return clip_w(neg ? from - longint'(q) : from + longint'(q), flag);
	endfunction

	// Map one item through the trapezoid; returns 0 when the item gives no result.
	function automatic bit map_weight(cfg_t c, in_t x, output out_t r);
		longint lo_w, hi_w, m1, x1, x2, m2, dlo, dhi, w, cur, res;
		bit flag;
		logic [2:0] seg;
		lo_w = c.driver_low;  hi_w = c.driver_high;
		m1 = c.rise_start;    x1 = c.rise_end;
		x2 = c.fall_start;    m2 = c.fall_end;
		dlo = c.driven_low;   dhi = c.driven_high;
		w = x.weight;
		flag = 1'b0;
		r = '0;
		if (x.animating) cur = w;
		else begin
			// max with driver_low first, then min with driver_high
			cur = w < lo_w ? lo_w : w;
			if (cur > hi_w) cur = hi_w;
		end
		if (x.animating && !x.driven_animates) return 1'b0;
		if (x.animating && cur < m1) begin
			seg = SEG_BELOW;
			if (m1 != lo_w) res = dlo;
			else if (m1 == x1) res = dhi;
			else res = slope_value(cur, m1, x1, dlo, dhi, flag);
		end else if (x.animating && cur > m2) begin
			seg = SEG_ABOVE;
			if (m2 != hi_w) res = dlo;
			else if (m2 == x2) res = dhi;
			else res = slope_value(cur, x2, m2, dhi, dlo, flag);
		end else if (cur <= m1) begin
			seg = SEG_BELOW;
			res = (m1 == x1 && m1 <= lo_w) ? dhi : dlo;
		end else if (cur <= x1) begin
			seg = SEG_RISE;
			res = slope_value(cur, m1, x1, dlo, dhi, flag);
		end else if (cur <= x2) begin
			seg = SEG_PLATEAU;
			res = dhi;
		end else if (cur <= m2) begin
			seg = SEG_FALL;
			res = slope_value(cur, x2, m2, dhi, dlo, flag);
		end else begin
			seg = SEG_ABOVE;
			res = (x2 >= hi_w) ? dhi : dlo;
		end
		r.mapped_weight = res[W-1:0];
		r.applied_weight = cur[W-1:0];
		r.segment = seg;
		r.saturated = flag;
		return 1'b1;
	endfunction

	// Weight with heavy weight on the extremes, zero, one and the range within four of zero.
	function automatic logic [W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(W-1){1'b0}}};
			1: return {1'b0, {(W-1){1'b1}}};
			2: return '0;
			3: return ONE_Q;
			4, 5: return W'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic [W-1:0] near(logic [W-1:0] p);
		case ($urandom_range(0, 3))
			0: return p;
			1: return p + W'($urandom_range(1, 3));
			2: return p - W'($urandom_range(1, 3));
			default: return p + W'($signed($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic cfg_t pick_cfg(int phase);
		cfg_t c;
		logic signed [W-1:0] v[4];
		logic signed [W-1:0] t;
		c.driver_low = pick_weight();
		c.driver_high = pick_weight();
		for (int i = 0; i < 4; i++) v[i] = pick_weight();
		if ($urandom_range(0, 4) != 0) begin
			// ordered breakpoints: the well-formed trapezoid
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 3 - i; j++)
					if (v[j] > v[j+1]) begin
						t = v[j];
						v[j] = v[j+1];
						v[j+1] = t;
					end
			if (c.driver_low > c.driver_high && $urandom_range(0, 3) != 0) begin
				t = c.driver_low;
				c.driver_low = c.driver_high;
				c.driver_high = t;
			end
		end
		c.rise_start = v[0];
		c.rise_end = v[1];
		c.fall_start = v[2];
		c.fall_end = v[3];
		// tie outer breakpoints to the driver limits to open extrapolation
		if ($urandom_range(0, 1)) c.rise_start = c.driver_low;
		if ($urandom_range(0, 1)) c.fall_end = c.driver_high;
		if ($urandom_range(0, 4) == 0) c.rise_end = c.rise_start;
		if ($urandom_range(0, 4) == 0) c.fall_start = c.fall_end;
		c.driven_low = pick_weight();
		c.driven_high = pick_weight();
		// fixed extremes for the first phases
		if (phase == 1) begin
			c.driver_low = {1'b1, {(W-1){1'b0}}};
			c.driver_high = {1'b0, {(W-1){1'b1}}};
			c.driven_low = {1'b1, {(W-1){1'b0}}};
			c.driven_high = {1'b0, {(W-1){1'b1}}};
		end else if (phase == 2) begin
			// steep short slopes at the limits: extrapolation saturates
			c.driver_low = -W'(65536);
			c.driver_high = W'(65536);
			c.rise_start = -W'(65536);
			c.rise_end = -W'(65535);
			c.fall_start = W'(65535);
			c.fall_end = W'(65536);
			c.driven_low = {1'b1, {(W-1){1'b0}}};
			c.driven_high = {1'b0, {(W-1){1'b1}}};
		end
		return c;
	endfunction

	function automatic in_t pick_item(cfg_t c);
		in_t x;
		case ($urandom_range(0, 6))
			0: x.weight = near(c.rise_start);
			1: x.weight = near(c.rise_end);
			2: x.weight = near(c.fall_start);
			3: x.weight = near(c.fall_end);
			4: x.weight = near($urandom_range(0, 1) ? c.driver_low : c.driver_high);
			default: x.weight = pick_weight();
		endcase
		x.animating = $urandom_range(0, 1) != 0;
		x.driven_animates = $urandom_range(0, 5) != 0;
		return x;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_cfg(cfg_t c);
		write_reg(REG_DRIVER_LOW, c.driver_low);
		write_reg(REG_DRIVER_HIGH, c.driver_high);
		write_reg(REG_RISE_START, c.rise_start);
		write_reg(REG_RISE_END, c.rise_end);
		write_reg(REG_FALL_START, c.fall_start);
		write_reg(REG_FALL_END, c.fall_end);
		write_reg(REG_DRIVEN_LOW, c.driven_low);
		write_reg(REG_DRIVEN_HIGH, c.driven_high);
		cur_cfg = c;
	endtask

	// Offer one item and hold it until accepted; valid stays high on return.
	task automatic offer(in_t x, bit typed, out_t want);
		out_t r;
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (typed) pending_results.insert(pending_results.size(), want);
		else if (map_weight(cur_cfg, x, r))
			pending_results.insert(pending_results.size(), r);
	endtask

	// Drain everything in flight, including bubbles that give no result.
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Receiver: check each accepted result, then pick the next ready level.
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_mode = 0;
	always @(posedge clk) begin
		out_t want;
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = pending_results.pop_front();
				if (result.mapped_weight !== want.mapped_weight ||
						result.applied_weight !== want.applied_weight ||
						result.segment !== want.segment ||
						result.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want dw=%h aw=%h seg=%0d sat=%b got dw=%h aw=%h seg=%0d sat=%b",
							want.mapped_weight, want.applied_weight, want.segment,
							want.saturated, result.mapped_weight, result.applied_weight,
							result.segment, result.saturated);
				end
			end
		end
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 300;
		end
		if (($urandom_range(0, 63)) == 0) stall_mode = $urandom_range(0, 3);
		if (hold_left > 0) begin
			// long hold-off: the pipeline fills and input stalls
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= $urandom_range(0, 3) != 0;
				2: result_ready <= $urandom_range(0, 1) != 0;
				default: result_ready <= ((cycles % 7) < 5);
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t dir[$];
		dir_row_t row;
		out_t none;
		int burst;
		none = '0;
		cur_cfg.driver_low = '0;
		cur_cfg.driver_high = ONE_Q;
		cur_cfg.rise_start = '0;
		cur_cfg.rise_end = ONE_Q;
		cur_cfg.fall_start = ONE_Q;
		cur_cfg.fall_end = ONE_Q;
		cur_cfg.driven_low = '0;
		cur_cfg.driven_high = ONE_Q;

		// Directed rows against the reset registers; typed where obvious.
		row = '{'{W'(0), 1'b0, 1'b1}, 1'b1, '{W'(0), W'(0), SEG_BELOW, 1'b0}};
		dir.insert(dir.size(), row);
		row = '{'{{1'b0, {(W-1){1'b1}}}, 1'b0, 1'b0}, 1'b1,
			'{ONE_Q, ONE_Q, SEG_RISE, 1'b0}};
		dir.insert(dir.size(), row);
		row = '{'{{1'b1, {(W-1){1'b0}}}, 1'b0, 1'b1}, 1'b1,
			'{W'(0), W'(0), SEG_BELOW, 1'b0}};
		dir.insert(dir.size(), row);
		// animating with a still driven side: no result at all
		row = '{'{W'(12345), 1'b1, 1'b0}, 1'b0, none};
		dir.insert(dir.size(), row);
		row = '{'{{1'b1, {(W-1){1'b0}}}, 1'b1, 1'b1}, 1'b1,
			'{{1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}}, SEG_BELOW, 1'b0}};
		dir.insert(dir.size(), row);
		row = '{'{{1'b0, {(W-1){1'b1}}}, 1'b1, 1'b1}, 1'b1,
			'{ONE_Q, {1'b0, {(W-1){1'b1}}}, SEG_ABOVE, 1'b0}};
		dir.insert(dir.size(), row);
		row = '{'{W'(32768), 1'b0, 1'b1}, 1'b1, '{W'(32768), W'(32768), SEG_RISE, 1'b0}};
		dir.insert(dir.size(), row);
		row = '{'{W'(0), 1'b1, 1'b1}, 1'b1, '{W'(0), W'(0), SEG_BELOW, 1'b0}};
		dir.insert(dir.size(), row);
		row = '{'{-W'(1), 1'b1, 1'b0}, 1'b0, none};
		dir.insert(dir.size(), row);
		row = '{'{W'(40000), 1'b1, 1'b1}, 1'b0, none};
		dir.insert(dir.size(), row);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) offer(dir[i].x, dir[i].typed, dir[i].want);
		settle();

		// Random phases: new registers only once the pipeline is empty.
		for (int ph = 1; ph < N_PHASES; ph++) begin
			load_cfg(pick_cfg(ph));
			burst = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 5 && k == 3) hold_go = 1'b1;
				offer(pick_item(cur_cfg), 1'b0, none);
				if (ph != 5 && burst <= 0) begin
					burst = $urandom_range(1, 12);
					if ($urandom_range(0, 2) != 0) begin
						item_valid <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
					end
				end
				burst--;
			end
			settle();
		end

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
